// ===== sv/grid_ray_traversal_macros.svh =====
// Assertion macros shared by the grid ray traversal checker.
// Bodies refer to the clk and rst signals of the module that uses them.
`ifndef GRID_RAY_TRAVERSAL_MACROS_SVH
`define GRID_RAY_TRAVERSAL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/grt_pkg.sv =====
// Shared types and constants of the grid ray traversal block.
// No dependencies; the files that use it refer to it by scoped names.
package grt_pkg;

  // Fixed point format of coordinates and distances.
  localparam int FRAC_BITS = 12;

  // Internal widths.
  localparam int MAG_W  = 21;  // magnitude of a delta component
  localparam int LEN_W  = 22;  // ray length
  localparam int DIST_W = 32;  // saturated boundary distances
  localparam int DIV_W  = 44;  // dividend, quotient and radicand width
  localparam int CELL_W = 12;  // signed cell coordinate
  localparam int HIT_W  = 23;  // signed hit point before truncation

  // Tile codes.
  localparam logic [7:0] TILE_EMPTY = 8'h2E;
  localparam logic [7:0] TILE_WALL  = 8'h23;

  // Face normal codes.
  localparam logic [2:0] NORM_NONE  = 3'd0;
  localparam logic [2:0] NORM_POS_X = 3'd1;
  localparam logic [2:0] NORM_NEG_X = 3'd2;
  localparam logic [2:0] NORM_POS_Y = 3'd3;
  localparam logic [2:0] NORM_NEG_Y = 3'd4;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   dividend;
    logic [LEN_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_W-1:0]   quotient;
  } div_rsp_t;

  // Square root request and response.
  typedef struct packed {
    logic               start;
    logic [DIV_W-1:0]   radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic               done;
    logic [LEN_W-1:0]   root;
  } sqrt_rsp_t;

endpackage

// ===== sv/grid_ray_traversal.sv =====
// Grid ray traversal: a write stores one tile; a trace computes squares, a root and two
// step divisions, then steps cell by cell (a store read per cell in the map), and on a
// hit runs two hit point divisions. One item is worked on at a time, all divisions on
// the shared divider. Reset clears control state only; the tile store is not cleared.
module grid_ray_traversal #(
  parameter int MAP_WIDTH  = 16,
  parameter int MAP_HEIGHT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cell_index, cell_tile, start_x, start_y, end_x, end_y, only_walls, zero fill
  input  logic [95:0] s_tdata,
  // kind
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // did_hit, hit_tile, hit_x, hit_y, hit_distance, face_normal, zero fill
  output logic [79:0] m_tdata
);

  localparam int FB    = grt_pkg::FRAC_BITS;
  localparam int MW    = grt_pkg::MAG_W;
  localparam int LW    = grt_pkg::LEN_W;
  localparam int DSW   = grt_pkg::DIST_W;
  localparam int DW    = grt_pkg::DIV_W;
  localparam int CellW = grt_pkg::CELL_W;
  localparam int HW    = grt_pkg::HIT_W;
  localparam int PW    = LW + DSW;
  localparam int OW    = HW + 3;

  localparam logic signed [CellW-1:0] MapW  = CellW'(MAP_WIDTH);
  localparam logic signed [CellW-1:0] MapH  = CellW'(MAP_HEIGHT);
  localparam logic [7:0]              MapWLo = 8'(MAP_WIDTH);

  typedef enum logic [4:0] {
    S_IDLE, S_SQX, S_SQY, S_SQRT, S_SQRT_W, S_DIVX, S_DIVX_W, S_DIVY, S_DIVY_W,
    S_RX, S_RY, S_RCAP, S_STEP, S_TEST, S_ALX, S_ALX_D, S_ALX_W, S_ALY, S_ALY_D,
    S_ALY_W, S_NORM, S_DONE
  } state_t;

  state_t state;

  // Trace registers.
  logic [15:0]            sx, sy;
  logic signed [20:0]     ex, ey;
  logic                   walls;
  logic                   negx, negy;
  logic [MW-1:0]          adx, ady;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          sq_acc;
  logic [LW-1:0]          len;
  logic [DSW-1:0]         stx, sty, rx, ry, ray_dist;
  logic signed [CellW-1:0] cx, cy;
  logic                   hit;
  logic [7:0]             tile;
  logic signed [HW-1:0]   hx, hy;
  logic [2:0]             normal;

  // Input decode.
  logic                   in_acc;
  logic signed [MW:0]     dxc, dyc;
  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign dxc = $signed({s_tdata[68], s_tdata[68:48]}) - $signed({6'b0, s_tdata[31:16]});
  assign dyc = $signed({s_tdata[89], s_tdata[89:69]}) - $signed({6'b0, s_tdata[47:32]});

  // Shared multiplier with a registered product.
  logic [LW-1:0]  mul_a;
  logic [DSW-1:0] mul_b;
  logic [FB:0]    fx, fy;
  always_comb begin
    fx = negx ? {1'b0, sx[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, sx[FB-1:0]};
    fy = negy ? {1'b0, sy[FB-1:0]} : (FB+1)'(1 << FB) - {1'b0, sy[FB-1:0]};
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin mul_a = LW'(adx); mul_b = DSW'(adx); end
      S_SQY: begin mul_a = LW'(ady); mul_b = DSW'(ady); end
      S_RX:  begin mul_a = LW'(fx);  mul_b = stx;       end
      S_RY:  begin mul_a = LW'(fy);  mul_b = sty;       end
      S_ALX: begin mul_a = LW'(adx); mul_b = ray_dist;  end
      S_ALY: begin mul_a = LW'(ady); mul_b = ray_dist;  end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // Square root and divider units.
  grt_pkg::sqrt_req_t sqrt_req;
  grt_pkg::sqrt_rsp_t sqrt_rsp;
  grt_pkg::div_req_t  div_req;
  grt_pkg::div_rsp_t  div_rsp;

  always_comb begin
    sqrt_req.start    = (state == S_SQRT);
    sqrt_req.radicand = DW'(sq_acc) + DW'(prod);
    div_req.start     = 1'b0;
    div_req.dividend  = DW'({len, FB'(0)});
    div_req.divisor   = LW'(adx);
    case (state) inside
      S_DIVX: begin
        div_req.start   = (adx != '0);
        div_req.divisor = LW'(adx);
      end
      S_DIVY: begin
        div_req.start   = (ady != '0);
        div_req.divisor = LW'(ady);
      end
      S_ALX_D, S_ALY_D: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DW-1:0];
        div_req.divisor  = len;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  grt_sqrt u_sqrt (.clk(clk), .rst(rst), .req(sqrt_req), .rsp(sqrt_rsp));
  grt_divider u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // One DDA step: cross the nearer boundary.
  logic                    xstep;
  logic [DSW-1:0]          ray_dist_next;
  logic signed [CellW-1:0] cx_next, cy_next;
  logic [DSW:0]            racc;
  logic [DSW-1:0]          racc_sat;
  logic                    in_map;
  logic [7:0]              raddr;
  always_comb begin
    xstep         = rx < ry;
    ray_dist_next = xstep ? rx : ry;
    cx_next       = cx;
    cy_next       = cy;
    if (xstep) begin
      cx_next = negx ? cx - CellW'(1) : cx + CellW'(1);
    end else begin
      cy_next = negy ? cy - CellW'(1) : cy + CellW'(1);
    end
    racc     = xstep ? {1'b0, rx} + {1'b0, stx} : {1'b0, ry} + {1'b0, sty};
    racc_sat = racc[DSW] ? '1 : racc[DSW-1:0];
    in_map   = (cx_next >= 0) && (cx_next < MapW) && (cy_next >= 0) && (cy_next < MapH);
    raddr    = cy_next[7:0] * MapWLo + cx_next[7:0];
  end

  // Tile store.
  logic [7:0] rdata;
  logic       qualifies;
  grt_tile_mem u_mem (
    .clk(clk),
    .we(in_acc && !s_tuser),
    .waddr(s_tdata[7:0]),
    .wdata(s_tdata[15:8]),
    .raddr(raddr),
    .rdata(rdata)
  );
  assign qualifies = walls ? (rdata == grt_pkg::TILE_WALL) : (rdata != grt_pkg::TILE_EMPTY);

  // Hit point offsets from the cell center for the face normal.
  logic signed [OW-1:0] ox, oy, aox, aoy;
  always_comb begin
    ox  = OW'(hx) - (OW'(cx) <<< FB) - OW'(1 << (FB - 1));
    oy  = OW'(hy) - (OW'(cy) <<< FB) - OW'(1 << (FB - 1));
    aox = ox[OW-1] ? -ox : ox;
    aoy = oy[OW-1] ? -oy : oy;
  end

  logic [19:0] dist_out;
  assign dist_out = (ray_dist > DSW'(20'hFFFFF)) ? 20'hFFFFF : ray_dist[19:0];

  // The output register takes a new result when it is empty or being emptied.
  logic out_load;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && s_tuser) begin
            sx    <= s_tdata[31:16];
            sy    <= s_tdata[47:32];
            ex    <= s_tdata[68:48];
            ey    <= s_tdata[89:69];
            walls <= s_tdata[90];
            negx  <= dxc[MW];
            negy  <= dyc[MW];
            adx   <= dxc[MW] ? MW'(-dxc) : dxc[MW-1:0];
            ady   <= dyc[MW] ? MW'(-dyc) : dyc[MW-1:0];
            hit   <= 1'b0;
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          sq_acc <= prod;
          state  <= S_SQRT;
        end
        S_SQRT: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (sqrt_rsp.done) begin
            len   <= sqrt_rsp.root;
            state <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (adx == '0) begin
            stx   <= '1;
            state <= S_DIVY;
          end else begin
            state <= S_DIVX_W;
          end
        end
        S_DIVX_W: begin
          if (div_rsp.done) begin
            stx   <= (|div_rsp.quotient[DW-1:DSW]) ? '1 : div_rsp.quotient[DSW-1:0];
            state <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (ady == '0) begin
            sty   <= '1;
            state <= S_RX;
          end else begin
            state <= S_DIVY_W;
          end
        end
        S_DIVY_W: begin
          if (div_rsp.done) begin
            sty   <= (|div_rsp.quotient[DW-1:DSW]) ? '1 : div_rsp.quotient[DSW-1:0];
            state <= S_RX;
          end
        end
        S_RX: state <= S_RY;
        S_RY: begin
          rx    <= (|prod[PW-1:FB+DSW]) ? '1 : prod[FB+DSW-1:FB];
          state <= S_RCAP;
        end
        S_RCAP: begin
          ry       <= (|prod[PW-1:FB+DSW]) ? '1 : prod[FB+DSW-1:FB];
          ray_dist <= '0;
          cx       <= CellW'(sx[15:FB]);
          cy       <= CellW'(sy[15:FB]);
          hx       <= HW'(ex);
          hy       <= HW'(ey);
          state    <= S_STEP;
        end
        S_STEP: begin
          if (ray_dist >= DSW'(len)) begin
            state <= S_DONE;
          end else begin
            ray_dist <= ray_dist_next;
            cx       <= cx_next;
            cy       <= cy_next;
            if (xstep) begin
              rx <= racc_sat;
            end else begin
              ry <= racc_sat;
            end
            if (ray_dist_next > DSW'(len)) begin
              state <= S_DONE;
            end else if (in_map) begin
              state <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (qualifies) begin
            hit   <= 1'b1;
            tile  <= rdata;
            state <= S_ALX;
          end else begin
            state <= S_STEP;
          end
        end
        S_ALX:   state <= S_ALX_D;
        S_ALX_D: state <= S_ALX_W;
        S_ALX_W: begin
          if (div_rsp.done) begin
            hx <= negx ? HW'(sx) - HW'(div_rsp.quotient[MW-1:0])
                       : HW'(sx) + HW'(div_rsp.quotient[MW-1:0]);
            state <= S_ALY;
          end
        end
        S_ALY:   state <= S_ALY_D;
        S_ALY_D: state <= S_ALY_W;
        S_ALY_W: begin
          if (div_rsp.done) begin
            hy <= negy ? HW'(sy) - HW'(div_rsp.quotient[MW-1:0])
                       : HW'(sy) + HW'(div_rsp.quotient[MW-1:0]);
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (aox > aoy) begin
            normal <= (ox > 0) ? grt_pkg::NORM_POS_X : grt_pkg::NORM_NEG_X;
          end else begin
            normal <= (oy > 0) ? grt_pkg::NORM_POS_Y : grt_pkg::NORM_NEG_Y;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata <= {6'b0,
                        hit ? normal : grt_pkg::NORM_NONE,
                        dist_out,
                        hy[20:0],
                        hx[20:0],
                        hit ? tile : 8'h00,
                        hit};
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/grt_tile_mem.sv =====
// Tile map store: 256 entries of 8 bits, one write and one registered read port.
// Depends on nothing else.
module grt_tile_mem (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [256];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/grt_divider.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on grt_pkg for the request and response structs.
module grt_divider (
  input  logic              clk,
  input  logic              rst,
  input  grt_pkg::div_req_t req,
  output grt_pkg::div_rsp_t rsp
);

  localparam int DW = grt_pkg::DIV_W;
  localparam int VW = grt_pkg::LEN_W;

  logic          busy;
  logic          done;
  logic [5:0]    cnt;
  logic [DW-1:0] quo;
  logic [VW-1:0] rem;
  logic [VW-1:0] divs;
  logic [VW:0]   shifted;
  logic          q_bit;
  logic [VW-1:0] rem_next;

  // One trial subtraction.
  always_comb begin
    shifted  = {rem, quo[DW-1]};
    q_bit    = shifted >= {1'b0, divs};
    rem_next = q_bit ? VW'(shifted - {1'b0, divs}) : shifted[VW-1:0];
  end

  // Iteration control; the dividend register collects the quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 6'd0);
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        divs <= req.divisor;
        cnt  <= 6'(DW - 1);
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[DW-2:0], q_bit};
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo};

endmodule

// ===== sv/grt_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
// Depends on grt_pkg for the request and response structs.
module grt_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  grt_pkg::sqrt_req_t req,
  output grt_pkg::sqrt_rsp_t rsp
);

  localparam int DW = grt_pkg::DIV_W;

  logic          busy;
  logic          done;
  logic [4:0]    cnt;
  logic [DW-1:0] v;
  logic [DW-1:0] res;
  logic [DW-1:0] bitv;
  logic [DW-1:0] trial;
  logic          ge;

  // One digit step.
  always_comb begin
    trial = res + bitv;
    ge    = v >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (cnt == 5'd0);
      if (req.start) begin
        busy <= 1'b1;
        v    <= req.radicand;
        res  <= '0;
        bitv <= DW'(1) << (DW - 2);
        cnt  <= 5'(DW / 2 - 1);
      end else if (busy) begin
        v    <= ge ? v - trial : v;
        res  <= ge ? (res >> 1) + bitv : res >> 1;
        bitv <= bitv >> 2;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp = '{done: done, root: res[grt_pkg::LEN_W-1:0]};

endmodule

// ===== sv/grt_checker.sv =====
// Port-level checks of the grid ray traversal block, bound to its top level.
// Depends on grt_pkg and grid_ray_traversal_macros.svh.
`include "grid_ray_traversal_macros.svh"

module grt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata
);

  // A stalled result transfer keeps its payload.
  `GRT_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // A miss carries no tile and no normal.
  `GRT_ASSERT_IMP(a_miss_clean, m_tvalid && !m_tdata[0], m_tdata[8:1] == 8'h00 && m_tdata[73:71] == grt_pkg::NORM_NONE, "miss with tile or normal")

  // A hit always names a face.
  `GRT_ASSERT_IMP(a_hit_normal, m_tvalid && m_tdata[0], m_tdata[73:71] == grt_pkg::NORM_POS_X || m_tdata[73:71] == grt_pkg::NORM_NEG_X || m_tdata[73:71] == grt_pkg::NORM_POS_Y || m_tdata[73:71] == grt_pkg::NORM_NEG_Y, "hit without face normal")

  // A result never appears right after an input transfer.
  `GRT_ASSERT_IMP(a_no_instant, $rose(m_tvalid), !$past(s_tvalid && s_tready), "result in cycle after input")

endmodule

bind grid_ray_traversal grt_checker u_grt_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

// ===== tb/sv/grt_tb_pkg.sv =====
// Item kinds and the input item record shared by the grid ray traversal testbench.
// Used by the checker and the testbench top; no dependencies.
package grt_tb_pkg;

  // Codes carried on s_tuser.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_TRACE = 1'b1
  } item_kind_t;

  // One input item, unpacked.
  typedef struct {
    item_kind_t         kind;
    logic [7:0]         cell_index;
    logic [7:0]         cell_tile;
    logic [15:0]        start_x;
    logic [15:0]        start_y;
    logic signed [20:0] end_x;
    logic signed [20:0] end_y;
    logic               only_walls;
  } ray_item_t;

endpackage

// ===== tb/sv/grid_ray_traversal_checker.sv =====
// Checker for the grid ray traversal block: mirrors the tile map, predicts each trace
// result with a fixed point DDA walk and compares the result transfers. Uses grt_pkg.
module grid_ray_traversal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [95:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  output int          errors,
  output int          pending
);

  localparam int MAP_W = 16;
  localparam int MAP_H = 16;
  localparam longint unsigned SAT = 64'hFFFF_FFFF;

  typedef struct {
    logic               did_hit;
    logic [7:0]         tile;
    logic [20:0]        hx;
    logic [20:0]        hy;
    logic [19:0]        hit_dist;
    logic [2:0]         normal;
  } trace_result_t;

  logic [7:0]    tile_map [256];
  trace_result_t expected_results [$];

  assign pending = expected_results.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned clamp32(longint unsigned v);
    return (v > SAT) ? SAT : v;
  endfunction

  function automatic longint unsigned step_len(longint unsigned len, longint unsigned mag);
    if (mag == 0) return SAT;
    return clamp32((len << grt_pkg::FRAC_BITS) / mag);
  endfunction

  function automatic longint point_along(longint s, longint d, longint unsigned walk_dist,
                                         longint unsigned len);
    longint unsigned q;
    if (len == 0) return s;
    q = ((d < 0) ? longint'(-d) : longint'(d)) * walk_dist / len;
    return (d < 0) ? s - longint'(q) : s + longint'(q);
  endfunction

  // Walks the ray cell by cell against the mirrored map.
  function automatic trace_result_t walk_ray(grt_tb_pkg::ray_item_t it);
    trace_result_t r;
    longint sx, sy, ex, ey, dx, dy, hx, hy, ox, oy, aox, aoy, half;
    longint unsigned adx, ady, len, stx, sty, rx, ry, walk_dist, one, fmask;
    int cx, cy, dirx, diry;
    logic [7:0] t;
    logic hit;
    one = 64'd1 << grt_pkg::FRAC_BITS;
    fmask = one - 1;
    half = longint'(one >> 1);
    sx = longint'(it.start_x);
    sy = longint'(it.start_y);
    ex = longint'(it.end_x);
    ey = longint'(it.end_y);
    dx = ex - sx;
    dy = ey - sy;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    len = floor_root(adx * adx + ady * ady);
    stx = step_len(len, adx);
    sty = step_len(len, ady);
    cx = int'(sx >>> grt_pkg::FRAC_BITS);
    cy = int'(sy >>> grt_pkg::FRAC_BITS);
    if (dx < 0) begin
      dirx = -1;
      rx = clamp32(((longint'(sx) & fmask) * stx) >> grt_pkg::FRAC_BITS);
    end else begin
      dirx = 1;
      rx = clamp32(((one - (longint'(sx) & fmask)) * stx) >> grt_pkg::FRAC_BITS);
    end
    if (dy < 0) begin
      diry = -1;
      ry = clamp32(((longint'(sy) & fmask) * sty) >> grt_pkg::FRAC_BITS);
    end else begin
      diry = 1;
      ry = clamp32(((one - (longint'(sy) & fmask)) * sty) >> grt_pkg::FRAC_BITS);
    end
    walk_dist = 0;
    hx = ex;
    hy = ey;
    hit = 1'b0;
    r.tile = 8'd0;
    r.normal = grt_pkg::NORM_NONE;
    while (!hit && walk_dist < len) begin
      if (rx < ry) begin
        cx += dirx;
        walk_dist = rx;
        rx = clamp32(rx + stx);
      end else begin
        cy += diry;
        walk_dist = ry;
        ry = clamp32(ry + sty);
      end
      if (walk_dist > len) break;
      if (cx >= 0 && cx < MAP_W && cy >= 0 && cy < MAP_H) begin
        t = tile_map[(cy * MAP_W + cx) & 255];
        if ((!it.only_walls && t != grt_pkg::TILE_EMPTY) ||
            (it.only_walls && t == grt_pkg::TILE_WALL)) begin
          hit = 1'b1;
          r.tile = t;
          hx = point_along(sx, dx, walk_dist, len);
          hy = point_along(sy, dy, walk_dist, len);
          ox = hx - longint'(cx) * longint'(one) - half;
          oy = hy - longint'(cy) * longint'(one) - half;
          aox = (ox < 0) ? -ox : ox;
          aoy = (oy < 0) ? -oy : oy;
          if (aox > aoy) r.normal = (ox > 0) ? grt_pkg::NORM_POS_X : grt_pkg::NORM_NEG_X;
          else r.normal = (oy > 0) ? grt_pkg::NORM_POS_Y : grt_pkg::NORM_NEG_Y;
        end
      end
    end
    r.did_hit = hit;
    r.hx = hx[20:0];
    r.hy = hy[20:0];
    r.hit_dist = (walk_dist > 64'hF_FFFF) ? 20'hF_FFFF : walk_dist[19:0];
    return r;
  endfunction

  // Input transfers: update the map or queue the predicted result.
  always @(posedge clk) begin
    grt_tb_pkg::ray_item_t it;
    if (!rst && s_tvalid && s_tready) begin
      it.kind       = grt_tb_pkg::item_kind_t'(s_tuser);
      it.cell_index = s_tdata[7:0];
      it.cell_tile  = s_tdata[15:8];
      it.start_x    = s_tdata[31:16];
      it.start_y    = s_tdata[47:32];
      it.end_x      = s_tdata[68:48];
      it.end_y      = s_tdata[89:69];
      it.only_walls = s_tdata[90];
      if (it.kind == grt_tb_pkg::KIND_WRITE) tile_map[it.cell_index] = it.cell_tile;
      else expected_results.push_back(walk_ray(it));
    end
  end

  // Result transfers: compare against the oldest prediction.
  initial errors = 0;
  always @(posedge clk) begin
    trace_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (m_tdata[0] !== e.did_hit) begin
          $error("did_hit expected %0d actual %0d", e.did_hit, m_tdata[0]);
          errors++;
        end
        if (m_tdata[8:1] !== e.tile) begin
          $error("hit_tile expected %h actual %h", e.tile, m_tdata[8:1]);
          errors++;
        end
        if (m_tdata[29:9] !== e.hx) begin
          $error("hit_x expected %h actual %h", e.hx, m_tdata[29:9]);
          errors++;
        end
        if (m_tdata[50:30] !== e.hy) begin
          $error("hit_y expected %h actual %h", e.hy, m_tdata[50:30]);
          errors++;
        end
        if (m_tdata[70:51] !== e.hit_dist) begin
          $error("hit_distance expected %h actual %h", e.hit_dist, m_tdata[70:51]);
          errors++;
        end
        if (m_tdata[73:71] !== e.normal) begin
          $error("face_normal expected %0d actual %0d", e.normal, m_tdata[73:71]);
          errors++;
        end
      end
    end
  end

endmodule

// ===== tb/sv/grid_ray_traversal_tb.sv =====
// Testbench top for the grid ray traversal block: loads tile maps, sends directed and
// random ray traces, and gives the verdict. Uses grt_tb_pkg and the checker module.
module grid_ray_traversal_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;
  int          errors;
  int          pending;

  // Sink control shared between the stimulus and the result sink; ready_seen serves the stimulus only.
  logic        hold_req;
  logic        hold_done;
  logic        sink_calm;
  logic        ready_seen;

  grid_ray_traversal dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  grid_ray_traversal_checker checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Ready as seen just before the next rising edge.
  always @(negedge clk) ready_seen <= s_tready;

  initial begin
    #80_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // One transfer on the input side, followed by an optional idle gap.
  task automatic send(grt_tb_pkg::ray_item_t it, bit idle);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= it.kind;
    s_tdata  <= {5'd0, it.only_walls, it.end_y, it.end_x, it.start_y, it.start_x,
                 it.cell_tile, it.cell_index};
    @(posedge clk);
    while (!ready_seen) @(posedge clk);
    gap = idle ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_cell(logic [7:0] idx, logic [7:0] tile, bit idle);
    grt_tb_pkg::ray_item_t it;
    it.kind = grt_tb_pkg::KIND_WRITE;
    it.cell_index = idx;
    it.cell_tile = tile;
    it.start_x = 16'($urandom);
    it.start_y = 16'($urandom);
    it.end_x = 21'($urandom);
    it.end_y = 21'($urandom);
    it.only_walls = 1'($urandom);
    send(it, idle);
  endtask

  task automatic trace(logic [15:0] sx, logic [15:0] sy, logic signed [20:0] ex,
                       logic signed [20:0] ey, logic walls, bit idle);
    grt_tb_pkg::ray_item_t it;
    it.kind = grt_tb_pkg::KIND_TRACE;
    it.cell_index = 8'($urandom);
    it.cell_tile = 8'($urandom);
    it.start_x = sx;
    it.start_y = sy;
    it.end_x = ex;
    it.end_y = ey;
    it.only_walls = walls;
    send(it, idle);
  endtask

  // Rewrites the whole map; density is the percentage of non-empty cells.
  task automatic load_map(int density);
    logic [7:0] tile;
    for (int i = 0; i < 256; i++) begin
      if ($urandom_range(0, 99) >= density) tile = 8'h2E;
      else if ($urandom_range(0, 1) == 0) tile = 8'h23;
      else tile = 8'($urandom);
      write_cell(i[7:0], tile, $urandom_range(0, 3) == 0);
    end
  endtask

  function automatic logic signed [20:0] near_end(logic [15:0] s, int span);
    return 21'(int'(s) + $urandom_range(0, 2 * span) - span);
  endfunction

  // A random trace: mostly short rays, some medium, a few across the whole range.
  task automatic random_trace();
    logic [15:0] sx, sy;
    logic signed [20:0] ex, ey;
    int r;
    sx = 16'($urandom);
    sy = 16'($urandom);
    r = int'($urandom_range(0, 99));
    if (r < 80) begin
      ex = near_end(sx, 16384);
      ey = near_end(sy, 16384);
    end else if (r < 95) begin
      ex = near_end(sx, 81920);
      ey = near_end(sy, 81920);
    end else begin
      ex = 21'($urandom);
      ey = 21'($urandom);
    end
    r = int'($urandom_range(0, 19));
    if (r == 0) ex = 21'(sx);
    else if (r == 1) ey = 21'(sy);
    trace(sx, sy, ex, ey, 1'($urandom), !sink_calm);
  endtask

  // Result sink: random ready with bursts, calm stretches and one long hold-off.
  initial begin
    int gap;
    m_tready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = sink_calm ? 0 : pick_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= grt_tb_pkg::KIND_WRITE;
    hold_req = 1'b0;
    sink_calm = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Mixed random map, then a wall in cell 0 and extreme tile codes.
    load_map(30);
    write_cell(8'd0, 8'h23, 1'b0);
    write_cell(8'd255, 8'hFF, 1'b0);
    write_cell(8'd17, 8'h00, 1'b0);

    // Directed traces.
    trace(16'h5800, 16'h5800, 21'sh05800, 21'sh05800, 1'b0, 1'b0);  // zero length
    trace(16'h5000, 16'h5800, 21'sh0F000, 21'sh05800, 1'b0, 1'b0);  // pure +x
    trace(16'h5000, 16'h5800, -21'sh02000, 21'sh05800, 1'b1, 1'b0); // pure -x
    trace(16'h5800, 16'h5000, 21'sh05800, 21'sh0F000, 1'b1, 1'b0);  // pure +y
    trace(16'h5800, 16'hA000, 21'sh05800, -21'sh08000, 1'b0, 1'b0); // pure -y
    trace(16'h0000, 16'h0000, 21'sh0FFFF, 21'sh0FFFF, 1'b0, 1'b0);  // corner start
    trace(16'hFFFF, 16'hFFFF, 21'sh00000, 21'sh00000, 1'b1, 1'b0);
    trace(16'hFFFF, 16'h0000, 21'sh0FFFFF, -21'sh100000, 1'b1, 1'b0);
    trace(16'h0000, 16'hFFFF, -21'sh100000, 21'sh0FFFFF, 1'b0, 1'b0);
    trace(16'h8000, 16'h8000, -21'sh100000, -21'sh100000, 1'b1, 1'b0);
    trace(16'h1234, 16'h4321, 21'sh01300, 21'sh04400, 1'b0, 1'b0); // inside one cell
    trace(16'h7FFF, 16'h8001, 21'sh09000, 21'sh07000, 1'b1, 1'b0);
    trace(16'h3000, 16'h3000, 21'sh0F000, 21'sh0F000, 1'b0, 1'b0); // exact diagonal
    trace(16'h2800, 16'hC800, 21'sh0E800, 21'sh02800, 1'b1, 1'b0);

    // Random traces, first over the mixed map, then over a clear map.
    for (int phase = 0; phase < 2; phase++) begin
      if (phase == 1) begin
        // Clear map: rays leave the map and run to their end points.
        load_map(0);
        trace(16'h8000, 16'h8000, 21'sh0FFFFF, 21'sh0C000, 1'b0, 1'b0);
        trace(16'h8000, 16'h8000, -21'sh0C000, -21'sh100000, 1'b1, 1'b0);
        trace(16'h8000, 16'h8000, 21'sh28000, 21'sh08000, 1'b0, 1'b0);
      end
      for (int n = 0; n < 160; n++) begin
        if (n == 60) sink_calm = 1'b1;
        if (n == 100) sink_calm = 1'b0;
        if (phase == 0 && n == 120) begin
          // Long sink hold-off while traces keep coming.
          hold_req = 1'b1;
          repeat (10) random_trace();
          while (!hold_done) @(posedge clk);
          hold_req = 1'b0;
        end
        if (n == 140) begin
          // Drain before going on.
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        if ($urandom_range(0, 99) < 12) write_cell(8'($urandom), 8'($urandom), !sink_calm);
        else random_trace();
      end
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
